/* sv/bsl_pkg.sv */
// ----------------------------------------------------------------------------
// bsl_pkg
// Shared widths, codes and transfer types of the segment loader.
// ----------------------------------------------------------------------------
package bsl_pkg;

    // fixed field widths
    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int COUNT_W = 24;

    // defaults handed down from the top level
    localparam int ADDRESS_BITS_DEFAULT = 16;
    localparam int QUEUE_DEPTH_DEFAULT  = 2;

    // constants of the file format and tracking
    localparam logic [ADDR_W-1:0]  HEADER_MARK = 16'hFFFF;
    localparam logic [ADDR_W-1:0]  MIN_NONE    = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 24'hFFFFFF;

    // status codes
    typedef enum logic [1:0] {
        ST_LOADING  = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_REJECTED = 2'd2,
        ST_TRUNC    = 2'd3
    } status_t;

    // classified byte from the parser to the tracking unit
    typedef struct packed {
        logic              clear;
        logic              track;
        logic              wvalid;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        status_t           status;
        logic [ADDR_W-1:0] seg_start;
        logic [ADDR_W-1:0] seg_end;
    } front_item_t;

    // finished result item
    typedef struct packed {
        logic               write_valid;
        logic [ADDR_W-1:0]  write_address;
        logic [DATA_W-1:0]  write_data;
        status_t            status;
        logic [ADDR_W-1:0]  lowest_address;
        logic [ADDR_W-1:0]  highest_address;
        logic [COUNT_W-1:0] data_bytes;
    } result_t;

endpackage

/* sv/bsl_fifo.sv */
// ----------------------------------------------------------------------------
// bsl_fifo
// Small first-word-fall-through queue; full and empty decode a registered fill count.
// ----------------------------------------------------------------------------
module bsl_fifo
    import bsl_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT,
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* sv/bsl_front.sv */
// ----------------------------------------------------------------------------
// bsl_front
// Byte parser: walks the segment headers and classifies each byte.
// ----------------------------------------------------------------------------
module bsl_front
    import bsl_pkg::*;
#(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] byte_value,
    input  logic              first_of_file,
    input  logic              last_of_file,
    output logic              full,
    output logic              item_push,
    output front_item_t       item,
    input  logic              item_full
);

    localparam int EFF_BITS = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
    localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((17'd1 << EFF_BITS) - 17'd1);

    typedef enum logic [2:0] {
        PH_START_LO  = 3'd0,
        PH_START_HI  = 3'd1,
        PH_END_LO    = 3'd2,
        PH_END_HI    = 3'd3,
        PH_DATA      = 3'd4,
        PH_REJECTED  = 3'd5,
        PH_COMPLETE  = 3'd6,
        PH_TRUNCATED = 3'd7
    } phase_t;

    phase_t            phase_reg, phase_next, phase_cur;
    logic [DATA_W-1:0] hold_reg, hold_next, hold_cur;
    logic [ADDR_W-1:0] start_reg, start_next, start_cur;
    logic [ADDR_W-1:0] end_reg, end_next, end_cur;
    logic [ADDR_W-1:0] addr_reg, addr_next, addr_cur;
    logic [ADDR_W-1:0] word;
    logic              accept;

    assign full      = item_full;
    assign accept    = push && !item_full;
    assign item_push = accept;
    assign word      = {byte_value, hold_cur};

    // start of file restarts parsing
    always_comb
    begin
        phase_cur = first_of_file ? PH_START_LO : phase_reg;
        hold_cur  = first_of_file ? '0 : hold_reg;
        start_cur = first_of_file ? '0 : start_reg;
        end_cur   = first_of_file ? '0 : end_reg;
        addr_cur  = first_of_file ? '0 : addr_reg;
    end

    // phase step and classification
    always_comb
    begin
        phase_next = phase_cur;
        hold_next  = hold_cur;
        start_next = start_cur;
        end_next   = end_cur;
        addr_next  = addr_cur;
        item       = '0;
        item.clear = first_of_file;

        case (phase_cur)
            PH_START_LO:
            begin
                hold_next  = byte_value;
                phase_next = PH_START_HI;
            end
            PH_START_HI:
            begin
                if (word == HEADER_MARK)
                begin
                    phase_next = PH_START_LO;
                end
                else
                begin
                    start_next = word & ADDR_MASK;
                    phase_next = PH_END_LO;
                end
            end
            PH_END_LO:
            begin
                hold_next  = byte_value;
                phase_next = PH_END_HI;
            end
            PH_END_HI:
            begin
                end_next = word & ADDR_MASK;
                if ((word & ADDR_MASK) < start_cur)
                begin
                    phase_next = PH_REJECTED;
                end
                else
                begin
                    item.track = 1'b1;
                    addr_next  = start_cur;
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                item.wvalid = 1'b1;
                item.waddr  = addr_cur;
                item.wdata  = byte_value;
                if (addr_cur == end_cur)
                begin
                    phase_next = PH_START_LO;
                end
                else
                begin
                    addr_next = addr_cur + 1'b1;
                end
            end
            default:
            begin
                phase_next = phase_cur;
            end
        endcase

        // final byte closes the file
        if (last_of_file)
        begin
            if (phase_next == PH_START_LO)
            begin
                phase_next = PH_COMPLETE;
            end
            else if (phase_next inside {PH_START_HI, PH_END_LO, PH_END_HI, PH_DATA})
            begin
                phase_next = PH_TRUNCATED;
            end
        end

        item.seg_start = start_next;
        item.seg_end   = end_next;

        case (phase_next)
            PH_REJECTED:  item.status = ST_REJECTED;
            PH_COMPLETE:  item.status = ST_COMPLETE;
            PH_TRUNCATED: item.status = ST_TRUNC;
            default:      item.status = ST_LOADING;
        endcase
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START_LO;
            hold_reg  <= '0;
            start_reg <= '0;
            end_reg   <= '0;
            addr_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            hold_reg  <= hold_next;
            start_reg <= start_next;
            end_reg   <= end_next;
            addr_reg  <= addr_next;
        end
    end

endmodule

/* sv/bsl_back.sv */
// ----------------------------------------------------------------------------
// bsl_back
// Tracking unit: lowest start, highest end and saturating byte count.
// ----------------------------------------------------------------------------
module bsl_back
    import bsl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_empty,
    input  front_item_t item,
    output logic        item_pop,
    input  logic        res_full,
    output logic        res_push,
    output result_t     result
);

    logic [ADDR_W-1:0]  min_reg, min_next, min_cur;
    logic [ADDR_W-1:0]  max_reg, max_next, max_cur;
    logic [COUNT_W-1:0] count_reg, count_next, count_cur;
    logic               move;

    // one transfer per cycle, stalled by an empty inner or full result queue
    assign move     = !item_empty && !res_full;
    assign item_pop = move;
    assign res_push = move;

    // tracking update
    always_comb
    begin
        min_cur   = item.clear ? MIN_NONE : min_reg;
        max_cur   = item.clear ? '0 : max_reg;
        count_cur = item.clear ? '0 : count_reg;

        min_next   = min_cur;
        max_next   = max_cur;
        count_next = count_cur;

        if (item.track)
        begin
            if (item.seg_start < min_cur)
            begin
                min_next = item.seg_start;
            end
            if (item.seg_end > max_cur)
            begin
                max_next = item.seg_end;
            end
        end
        if (item.wvalid && (count_cur != COUNT_MAX))
        begin
            count_next = count_cur + 1'b1;
        end

        result.write_valid     = item.wvalid;
        result.write_address   = item.waddr;
        result.write_data      = item.wdata;
        result.status          = item.status;
        result.lowest_address  = min_next;
        result.highest_address = max_next;
        result.data_bytes      = count_next;
    end

    // tracking registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= MIN_NONE;
            max_reg   <= '0;
            count_reg <= '0;
        end
        else if (move)
        begin
            min_reg   <= min_next;
            max_reg   <= max_next;
            count_reg <= count_next;
        end
    end

endmodule

/* sv/binary_segment_loader_top.sv */
// A byte is registered in the middle queue, then in the result queue that drives the ports.
// Throughput: one byte per cycle while full is low; full rises when the middle queue is full.
// Two-entry queues between parser and tracking unit and on the result side let each stall alone.
// Reset: asynchronous, active low; queues empty, parser expects a start low byte,
// lowest address 65535, highest address and byte count zero.
// ----------------------------------------------------------------------------
// binary_segment_loader_top
// Segmented load file parser producing memory writes and load tracking.
// ----------------------------------------------------------------------------
module binary_segment_loader_top
    import bsl_pkg::*;
#(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [DATA_W-1:0]  byte_value,
    input  logic               first_of_file,
    input  logic               last_of_file,
    output logic               empty,
    input  logic               pop,
    output logic               write_valid,
    output logic [ADDR_W-1:0]  write_address,
    output logic [DATA_W-1:0]  write_data,
    output logic [1:0]         status,
    output logic [ADDR_W-1:0]  lowest_address,
    output logic [ADDR_W-1:0]  highest_address,
    output logic [COUNT_W-1:0] data_bytes
);

    front_item_t front_item;
    front_item_t mid_item;
    result_t     back_result;
    result_t     out_result;
    logic        mid_push, mid_full, mid_pop, mid_empty;
    logic        res_push, res_full;

    // parser
    bsl_front #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .byte_value    (byte_value),
        .first_of_file (first_of_file),
        .last_of_file  (last_of_file),
        .full          (full),
        .item_push     (mid_push),
        .item          (front_item),
        .item_full     (mid_full)
    );

    // queue between parser and tracking unit
    bsl_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(front_item_t))
    ) u_mid_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (mid_push),
        .push_data (front_item),
        .full      (mid_full),
        .pop       (mid_pop),
        .pop_data  (mid_item),
        .empty     (mid_empty)
    );

    // tracking unit
    bsl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_empty (mid_empty),
        .item       (mid_item),
        .item_pop   (mid_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .result     (back_result)
    );

    // result queue
    bsl_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(result_t))
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (back_result),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (out_result),
        .empty     (empty)
    );

    // result ports
    assign write_valid     = out_result.write_valid;
    assign write_address   = out_result.write_address;
    assign write_data      = out_result.write_data;
    assign status          = out_result.status;
    assign lowest_address  = out_result.lowest_address;
    assign highest_address = out_result.highest_address;
    assign data_bytes      = out_result.data_bytes;

    // a data byte is never reported with a rejected segment
    a_write_not_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && write_valid) |-> (status != ST_REJECTED))
        else $error("data write reported with rejected status");

    // every data write is counted
    a_write_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && write_valid) |-> (data_bytes != '0))
        else $error("data write with zero byte count");

    // once a segment is tracked, its range is ordered
    a_range_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (lowest_address != MIN_NONE)) |-> (lowest_address <= highest_address))
        else $error("lowest address above highest address");

endmodule
